[design/ggl_pkg.sv]
`timescale 1ns / 1ps

package ggl_pkg;

  localparam int MAX_LINES = 4096;
  localparam int LINE_CAP_I = ((MAX_LINES - 1) > 4095) ? 4095 : (MAX_LINES - 1);
  localparam logic [11:0] LINE_CAP = LINE_CAP_I[11:0];

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_PAGE_PX    = 2'd0;
  localparam logic [1:0] CFG_MARGIN_PX  = 2'd1;
  localparam logic [1:0] CFG_SCALE_Q8   = 2'd2;
  localparam logic [1:0] CFG_INDENT_PX  = 2'd3;

  localparam logic [11:0] RST_PAGE_PX   = 12'd1080;
  localparam logic [10:0] RST_MARGIN_PX = 11'd81;
  localparam logic [11:0] RST_SCALE_Q8  = 12'd256;
  localparam logic [9:0]  RST_INDENT_PX = 10'd30;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam int DIVD_W    = 28;
  localparam int DIVS_W    = 16;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic [11:0] page_px;
    logic [10:0] margin_px;
    logic [11:0] scale_q8;
    logic [9:0]  indent_px;
  } cfg_t;

  // Glyph after scaling, as it waits between front and back.
  typedef struct packed {
    logic [15:0] sw;
    logic [15:0] sh;
    logic        blank;
    logic        is_indented;
    logic        ends_paragraph;
  } item_t;

  function automatic logic [11:0] line_adv(input logic [11:0] cur);
    line_adv = (cur < LINE_CAP) ? cur + 12'd1 : cur;
  endfunction

endpackage

[design/greedy_glyph_line_breaker.sv]
`timescale 1ns / 1ps
// A glyph is registered in the front end, queued, then registered as a result by
// the back end; an oversized glyph with a positive text width first takes one
// multiply and a bit-serial divide. One glyph per cycle unless results stall; the
// divide holds the back end while a 4-entry queue keeps taking glyphs at the front.
// Reset (rst, synchronous) restores register defaults and empties the line state.

module greedy_glyph_line_breaker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        glyph_valid,
  output logic        glyph_stall,
  input  logic [11:0] glyph_width,
  input  logic [11:0] glyph_height,
  input  logic        blank,
  input  logic        is_indented,
  input  logic        ends_paragraph,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [11:0] line_index,
  output logic        placed,
  output logic        starts_line,
  output logic        oversized,
  output logic [15:0] out_width,
  output logic [15:0] out_height
);

  ggl_pkg::cfg_t  cfg;
  ggl_pkg::item_t push_item;
  ggl_pkg::item_t head;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.page_px   <= ggl_pkg::RST_PAGE_PX;
      cfg.margin_px <= ggl_pkg::RST_MARGIN_PX;
      cfg.scale_q8  <= ggl_pkg::RST_SCALE_Q8;
      cfg.indent_px <= ggl_pkg::RST_INDENT_PX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ggl_pkg::CFG_PAGE_PX:   cfg.page_px   <= cfg_data;
        ggl_pkg::CFG_MARGIN_PX: cfg.margin_px <= cfg_data[10:0];
        ggl_pkg::CFG_SCALE_Q8:  cfg.scale_q8  <= cfg_data;
        ggl_pkg::CFG_INDENT_PX: cfg.indent_px <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  ggl_front u_front (
    .clk            (clk),
    .rst            (rst),
    .scale_q8       (cfg.scale_q8),
    .glyph_valid    (glyph_valid),
    .glyph_stall    (glyph_stall),
    .glyph_width    (glyph_width),
    .glyph_height   (glyph_height),
    .blank          (blank),
    .is_indented    (is_indented),
    .ends_paragraph (ends_paragraph),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  ggl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  ggl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .line_index   (line_index),
    .placed       (placed),
    .starts_line  (starts_line),
    .oversized    (oversized),
    .out_width    (out_width),
    .out_height   (out_height)
  );

endmodule

[design/ggl_front.sv]
`timescale 1ns / 1ps

module ggl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [11:0]         scale_q8,
  input  logic                glyph_valid,
  output logic                glyph_stall,
  input  logic [11:0]         glyph_width,
  input  logic [11:0]         glyph_height,
  input  logic                blank,
  input  logic                is_indented,
  input  logic                ends_paragraph,
  input  logic                q_full,
  output logic                q_push,
  output ggl_pkg::item_t      q_item
);

  logic        f_valid;
  logic [11:0] f_gw;
  logic [11:0] f_gh;
  logic        f_space;
  logic        f_indented;
  logic        f_ends;
  logic        accept;
  logic [23:0] wprod;
  logic [23:0] hprod;
  logic [24:0] wround;
  logic [24:0] hround;

  assign glyph_stall = f_valid && q_full;
  assign accept      = glyph_valid && !glyph_stall;
  assign q_push      = f_valid && !q_full;

  assign wprod  = 24'(f_gw) * 24'(scale_q8);
  assign hprod  = 24'(f_gh) * 24'(scale_q8);
  assign wround = {1'b0, wprod} + 25'd255;
  assign hround = {1'b0, hprod} + 25'd255;

  always_comb begin
    q_item.sw             = wround[24] ? 16'hFFFF : wround[23:8];
    q_item.sh             = hround[24] ? 16'hFFFF : hround[23:8];
    q_item.blank          = f_space;
    q_item.is_indented    = f_indented;
    q_item.ends_paragraph = f_ends;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_gw       <= glyph_width;
      f_gh       <= glyph_height;
      f_space    <= blank;
      f_indented <= is_indented;
      f_ends     <= ends_paragraph;
    end
  end

endmodule

[design/ggl_fifo.sv]
`timescale 1ns / 1ps

module ggl_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ggl_pkg::item_t push_item,
  input  logic           pop,
  output ggl_pkg::item_t head,
  output logic           full,
  output logic           empty
);

  ggl_pkg::item_t                  mem [ggl_pkg::QDEPTH];
  logic [ggl_pkg::QPTR_W-1:0]      wr_ptr;
  logic [ggl_pkg::QPTR_W-1:0]      rd_ptr;
  logic [ggl_pkg::QPTR_W:0]        count;

  assign full  = (count == (ggl_pkg::QPTR_W+1)'(ggl_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

[design/ggl_div.sv]
`timescale 1ns / 1ps

module ggl_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ggl_pkg::DIVD_W-1:0]  dividend,
  input  logic [ggl_pkg::DIVS_W-1:0]  divisor,
  output logic                        done,
  output logic [ggl_pkg::DIVS_W-1:0]  quotient
);

  logic                           busy;
  logic [ggl_pkg::DIV_CNT_W-1:0]  cnt;
  logic [ggl_pkg::DIVS_W-1:0]     rem;
  logic [ggl_pkg::DIVD_W-1:0]     quo;
  logic [ggl_pkg::DIVS_W:0]       trial;
  logic                           ge;

  // Restoring division, one quotient bit per cycle. Dividend bits shift
  // out of the top of quo while quotient bits shift in at the bottom.
  assign trial    = {rem, quo[ggl_pkg::DIVD_W-1]};
  assign ge       = (trial >= {1'b0, divisor});
  assign quotient = quo[ggl_pkg::DIVS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ggl_pkg::DIV_CNT_W'(ggl_pkg::DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? ggl_pkg::DIVS_W'(trial - {1'b0, divisor}) : trial[ggl_pkg::DIVS_W-1:0];
      quo <= {quo[ggl_pkg::DIVD_W-2:0], ge};
    end
  end

endmodule

[design/ggl_back.sv]
`timescale 1ns / 1ps

module ggl_back (
  input  logic            clk,
  input  logic            rst,
  input  ggl_pkg::cfg_t   cfg,
  input  ggl_pkg::item_t  head,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            result_valid,
  input  logic            result_stall,
  output logic [11:0]     line_index,
  output logic            placed,
  output logic            starts_line,
  output logic            oversized,
  output logic [15:0]     out_width,
  output logic [15:0]     out_height
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV
  } state_t;

  state_t      state;
  logic [16:0] line_fill;
  logic [11:0] current_line;
  logic        line_has_glyphs;
  logic        prev_ended_paragraph;

  logic [15:0] sh_hold;
  logic [15:0] sw_hold;
  logic [11:0] tw_hold;
  logic [27:0] prod;

  logic        out_free;
  logic        div_start;
  logic        div_done;
  logic [15:0] div_q;

  logic [9:0]  add;
  logic [13:0] right_edge;
  logic [13:0] text_w;
  logic [17:0] fill;
  logic [18:0] fill_sw;
  logic        fits;
  logic        narrow;
  logic        tw_pos;
  logic        skip;
  logic [11:0] line1;
  logic [16:0] fresh_fill;

  assign out_free  = !result_valid || !result_stall;
  assign q_pop     = (state == ST_IDLE) && !q_empty && out_free;
  assign div_start = (state == ST_START);

  always_comb begin
    add        = (prev_ended_paragraph || head.is_indented) ? cfg.indent_px : 10'd0;
    right_edge = {2'b00, cfg.page_px} - {3'b000, cfg.margin_px};
    text_w     = {2'b00, cfg.page_px} - {2'b00, cfg.margin_px, 1'b0};
    fill       = {1'b0, line_fill} + {8'd0, add};
    fill_sw    = {1'b0, fill} + {3'd0, head.sw};
    // A negative right edge or text width can never be met.
    fits       = !head.is_indented && !right_edge[13]
                 && (fill_sw < {6'd0, right_edge[12:0]});
    narrow     = !text_w[13] && ({1'b0, head.sw} <= {4'd0, text_w[12:0]});
    tw_pos     = !text_w[13] && (text_w != 14'd0);
    skip       = head.blank && !line_has_glyphs;
    line1      = line_has_glyphs ? ggl_pkg::line_adv(current_line) : current_line;
    fresh_fill = 17'(cfg.margin_px) + 17'(head.sw) + 17'(add);
  end

  ggl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (sw_hold),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      result_valid         <= 1'b0;
      line_fill            <= 17'(ggl_pkg::RST_MARGIN_PX);
      current_line         <= '0;
      line_has_glyphs      <= 1'b0;
      prev_ended_paragraph <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            out_width  <= head.sw;
            out_height <= head.sh;
            placed     <= 1'b1;
            starts_line <= 1'b0;
            oversized  <= 1'b0;
            line_index <= current_line;
            result_valid <= 1'b1;
            if (skip) begin
              placed <= 1'b0;
            end else begin
              prev_ended_paragraph <= head.ends_paragraph;
              if (fits) begin
                starts_line     <= !line_has_glyphs;
                line_fill       <= fill_sw[16:0];
                line_has_glyphs <= 1'b1;
              end else if (narrow) begin
                current_line    <= line1;
                line_index      <= line1;
                starts_line     <= 1'b1;
                line_fill       <= fresh_fill;
                line_has_glyphs <= 1'b1;
              end else begin
                // Oversized: a line of its own, then move past it.
                line_index      <= line1;
                starts_line     <= 1'b1;
                oversized       <= 1'b1;
                current_line    <= ggl_pkg::line_adv(line1);
                line_fill       <= 17'(cfg.margin_px);
                line_has_glyphs <= 1'b0;
                if (tw_pos) begin
                  out_width    <= {4'd0, text_w[11:0]};
                  sh_hold      <= head.sh;
                  sw_hold      <= head.sw;
                  tw_hold      <= text_w[11:0];
                  result_valid <= 1'b0;
                  state        <= ST_MUL;
                end else begin
                  out_width  <= 16'd0;
                  out_height <= 16'd0;
                end
              end
            end
          end
        end
        ST_MUL: begin
          prod  <= 28'(sh_hold) * 28'(tw_hold);
          state <= ST_START;
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            out_height   <= div_q;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
